// ===== sv/wrms_pkg.sv =====
// wrms_pkg: shared constants, config struct, register codes and back-end state type
// for the weighted rms window filter; no dependencies
package wrms_pkg;

  localparam int unsigned MAX_HALF    = 2;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned VALUE_W   = 15;
  localparam int unsigned DEV_W     = 16;
  localparam int unsigned HALF_W    = 2;
  // squared sample is at most 2^30
  localparam int unsigned SQ_W      = 31;
  localparam int unsigned PROD_W    = SQ_W + WEIGHT_W;
  // at most five taps carry a nonzero weight
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned ACC_SHIFT = 16;
  // even width so the root bit starts on an even power
  localparam int unsigned ROOT_W    = ACC_W - ACC_SHIFT + 1;

  localparam logic [HALF_W-1:0]   HALF_WIDTH_RST    = 2'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_CENTER_RST = 16'd21845;
  localparam logic [WEIGHT_W-1:0] WEIGHT_NEAR_RST   = 16'd21845;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FAR_RST    = 16'd0;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH,
    REG_WEIGHT_CENTER,
    REG_WEIGHT_NEAR,
    REG_WEIGHT_FAR
  } cfg_reg_e;

  typedef struct packed {
    logic [HALF_W-1:0]   half_width;
    logic [WEIGHT_W-1:0] weight_center;
    logic [WEIGHT_W-1:0] weight_near;
    logic [WEIGHT_W-1:0] weight_far;
  } cfg_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_TAPS,
    BS_ROOT,
    BS_OUT
  } back_state_e;

  // bits of the effective half width and of a window age
  function automatic int unsigned half_bits(int unsigned max_half);
    return $clog2(max_half + 1);
  endfunction

  // job word: last flag, half width, centre age, window samples
  function automatic int unsigned job_w(int unsigned max_half);
    return 1 + 2 * half_bits(max_half) + (2 * max_half + 1) * SAMPLE_W;
  endfunction

endpackage

// ===== sv/wrms_fifo.sv =====
// wrms_fifo: small register queue of window jobs between front and back
// depends on nothing but its parameters
module wrms_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_push_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue empty after a push without pop");

endmodule

// ===== sv/wrms_front.sv =====
// wrms_front: takes sample beats, keeps the sample window and frame count,
// and turns each beat into zero to MaxHalf+1 window jobs; uses wrms_pkg
module wrms_front #(
  parameter int unsigned MaxHalf = wrms_pkg::MAX_HALF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [wrms_pkg::HALF_W-1:0]              half_width_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [wrms_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                                     frame_end_i,
  output logic                                     push_o,
  input  logic                                     full_i,
  output logic [wrms_pkg::job_w(MaxHalf)-1:0]      job_o
);
  import wrms_pkg::*;

  localparam int unsigned WinLen = 2 * MaxHalf + 1;
  localparam int unsigned HW     = half_bits(MaxHalf);
  localparam int unsigned CW     = $clog2(MaxHalf + 2);
  localparam int unsigned PW     = 3;
  localparam int unsigned CmpW   = (PW > CW) ? PW : CW;
  localparam int unsigned JobW   = job_w(MaxHalf);

  logic [SAMPLE_W-1:0] win_q [WinLen];
  logic [SAMPLE_W-1:0] win_d [WinLen];
  logic [PW-1:0]       pending_q, pending_d, pend_new;
  logic [CW-1:0]       left_q, left_d, cnt;
  logic [HW-1:0]       age_q, age_d, h_q, h_d, h_eff;
  logic                end_q, end_d;
  logic                accept;
  logic [CmpW-1:0]     pend_ext, hp1;

  assign in_stall_o = (left_q != '0);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (left_q != '0) && !full_i;

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (half_width_i == '0) begin
      h_eff = HW'(1);
    end else if (32'(half_width_i) > MaxHalf) begin
      h_eff = HW'(MaxHalf);
    end else begin
      h_eff = HW'(half_width_i);
    end
  end

  assign pend_new = (pending_q == '1) ? pending_q : pending_q + PW'(1);
  assign pend_ext = CmpW'(pend_new);
  assign hp1      = CmpW'(h_eff) + CmpW'(1);
  assign cnt      = (pend_ext < hp1) ? CW'(pend_ext) : CW'(hp1);

  always_comb begin
    win_d     = win_q;
    pending_d = pending_q;
    left_d    = left_q;
    age_d     = age_q;
    h_d       = h_q;
    end_d     = end_q;
    if (accept) begin
      for (int k = WinLen - 1; k > 0; k--) begin
        win_d[k] = win_q[k-1];
      end
      win_d[0]  = sample_i;
      pending_d = pend_new;
      h_d       = h_eff;
      end_d     = frame_end_i;
      if (frame_end_i) begin
        // flush every output still owed, oldest centre first
        left_d = cnt;
        age_d  = HW'(cnt - CW'(1));
      end else begin
        left_d = (pend_ext > CmpW'(h_eff)) ? CW'(1) : '0;
        age_d  = h_eff;
      end
    end else if (push_o) begin
      left_d = left_q - CW'(1);
      age_d  = age_q - HW'(1);
      if (left_q == CW'(1) && end_q) begin
        for (int k = 0; k < WinLen; k++) begin
          win_d[k] = '0;
        end
        pending_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinLen; k++) begin
        win_q[k] <= '0;
      end
      pending_q <= '0;
      left_q    <= '0;
      age_q     <= '0;
      h_q       <= '0;
      end_q     <= 1'b0;
    end else begin
      win_q     <= win_d;
      pending_q <= pending_d;
      left_q    <= left_d;
      age_q     <= age_d;
      h_q       <= h_d;
      end_q     <= end_d;
    end
  end

  always_comb begin
    job_o = '0;
    for (int k = 0; k < WinLen; k++) begin
      job_o[k*SAMPLE_W +: SAMPLE_W] = win_q[k];
    end
    job_o[WinLen*SAMPLE_W +: HW]      = age_q;
    job_o[WinLen*SAMPLE_W + HW +: HW] = h_q;
    job_o[JobW-1]                     = end_q && (age_q == '0);
  end

  a_end_makes_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_end_i) |=> (left_q != '0))
    else $error("frame end beat produced no job");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o[JobW-1]) |=> (pending_q == '0))
    else $error("frame count not cleared after last job");

endmodule

// ===== sv/wrms_back.sv =====
// wrms_back: per job, a serial weighted sum of squares, a bit-serial square
// root, frame step and deviation tracking and the output register; uses wrms_pkg
module wrms_back #(
  parameter int unsigned MaxHalf = wrms_pkg::MAX_HALF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wrms_pkg::cfg_t                      cfg_i,
  input  logic                                job_valid_i,
  input  logic [wrms_pkg::job_w(MaxHalf)-1:0] job_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wrms_pkg::VALUE_W-1:0]        filtered_value_o,
  output logic                                last_of_frame_o,
  output logic [wrms_pkg::VALUE_W-1:0]        step_max_o,
  output logic [wrms_pkg::DEV_W-1:0]          deviation_max_o
);
  import wrms_pkg::*;

  localparam int unsigned WinLen = 2 * MaxHalf + 1;
  localparam int unsigned HW     = half_bits(MaxHalf);
  localparam int unsigned KW     = $clog2(2 * MaxHalf + 2);
  localparam int unsigned AW     = $clog2(3 * MaxHalf + 2);
  localparam int unsigned IW     = $clog2(WinLen);
  localparam int unsigned JobW   = job_w(MaxHalf);
  localparam int unsigned DiffW  = VALUE_W + 3;

  back_state_e state_q, state_d;

  logic [JobW-1:0]            job_q;
  logic signed [SAMPLE_W-1:0] win_j [WinLen];
  logic [HW-1:0]              age_j, h_j;
  logic                       last_j;

  logic [KW-1:0]              k_q, two_h, tap_dist;
  logic                       issue, taps_done, load;
  logic [AW-1:0]              a_sum, idx;
  logic                       in_win;
  logic signed [SAMPLE_W-1:0] tap_s;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [WEIGHT_W-1:0]        tap_w;

  logic [SQ_W-1:0]            sq_q;
  logic [WEIGHT_W-1:0]        w_q;
  logic                       v1_q, v2_q;
  logic [PROD_W-1:0]          prod_q;
  logic [ACC_W-1:0]           acc_q;

  logic [ROOT_W-1:0]          rv_q, res_q, bit_q, trial;

  logic [VALUE_W-1:0]         val, step, new_step;
  logic [IW-1:0]              age_idx;
  logic signed [SAMPLE_W-1:0] centre;
  logic signed [DiffW-1:0]    diff, diff_abs;
  logic [DEV_W-1:0]           dev, new_dev;

  logic [VALUE_W-1:0]         prev_q, largest_step_q;
  logic                       have_prev_q;
  logic [DEV_W-1:0]           largest_dev_q;
  logic                       out_valid_q;

  // job unpack
  always_comb begin
    for (int k = 0; k < WinLen; k++) begin
      win_j[k] = signed'(job_q[k*SAMPLE_W +: SAMPLE_W]);
    end
  end
  assign age_j  = job_q[WinLen*SAMPLE_W +: HW];
  assign h_j    = job_q[WinLen*SAMPLE_W + HW +: HW];
  assign last_j = job_q[JobW-1];

  // tap select: tap k sits at distance k - h from the centre
  assign two_h    = KW'(h_j) << 1;
  assign issue    = (state_q == BS_TAPS) && (k_q <= two_h);
  assign a_sum    = AW'(age_j) + AW'(k_q);
  assign idx      = a_sum - AW'(h_j);
  assign in_win   = (a_sum >= AW'(h_j)) && (idx < AW'(WinLen));
  assign tap_s    = in_win ? win_j[idx[IW-1:0]] : '0;
  assign tap_dist = (k_q >= KW'(h_j)) ? k_q - KW'(h_j) : KW'(h_j) - k_q;
  assign sq_full  = tap_s * tap_s;

  always_comb begin
    if (tap_dist == KW'(0)) begin
      tap_w = cfg_i.weight_center;
    end else if (tap_dist == KW'(1)) begin
      tap_w = cfg_i.weight_near;
    end else if (tap_dist == KW'(2)) begin
      tap_w = cfg_i.weight_far;
    end else begin
      tap_w = '0;
    end
  end

  assign trial = res_q + bit_q;

  // finish: saturate, then step against the previous output and deviation against the centre sample
  assign val      = (|res_q[ROOT_W-1:VALUE_W]) ? '1 : res_q[VALUE_W-1:0];
  assign age_idx  = IW'(age_j);
  assign centre   = win_j[age_idx];
  assign diff     = signed'({3'b000, val}) - DiffW'(centre);
  assign diff_abs = diff[DiffW-1] ? -diff : diff;
  assign dev      = diff_abs[DEV_W-1:0];
  assign step     = (val > prev_q) ? val - prev_q : prev_q - val;
  assign new_step = (have_prev_q && step > largest_step_q) ? step : largest_step_q;
  assign new_dev  = (dev > largest_dev_q) ? dev : largest_dev_q;

  assign load  = (state_q == BS_OUT) && (!out_valid_q || !out_stall_i);
  assign pop_o = (state_q == BS_IDLE) && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    taps_done = 1'b0;
    case (state_q)
      BS_IDLE: begin
        if (job_valid_i) begin
          state_d = BS_TAPS;
        end
      end
      BS_TAPS: begin
        if (!issue && !v1_q && !v2_q) begin
          taps_done = 1'b1;
          state_d   = BS_ROOT;
        end
      end
      BS_ROOT: begin
        if (bit_q == ROOT_W'(1)) begin
          state_d = BS_OUT;
        end
      end
      BS_OUT: begin
        if (load) begin
          state_d = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    sq_q   <= SQ_W'(sq_full);
    w_q    <= tap_w;
    prod_q <= PROD_W'(sq_q) * PROD_W'(w_q);
    if (taps_done) begin
      rv_q  <= ROOT_W'(acc_q >> ACC_SHIFT);
      res_q <= '0;
      bit_q <= ROOT_W'(1) << (ROOT_W - 2);
    end else if (state_q == BS_ROOT) begin
      if (rv_q >= trial) begin
        rv_q  <= rv_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (load) begin
      filtered_value_o <= val;
      last_of_frame_o  <= last_j;
      step_max_o       <= last_j ? new_step : '0;
      deviation_max_o  <= last_j ? new_dev : '0;
    end
  end

  // control and frame tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q            <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      out_valid_q    <= 1'b0;
      prev_q         <= '0;
      have_prev_q    <= 1'b0;
      largest_step_q <= '0;
      largest_dev_q  <= '0;
    end else begin
      if (pop_o) begin
        k_q <= '0;
      end else if (issue) begin
        k_q <= k_q + KW'(1);
      end
      v1_q <= issue;
      v2_q <= v1_q;
      if (load) begin
        out_valid_q <= 1'b1;
        if (last_j) begin
          prev_q         <= '0;
          have_prev_q    <= 1'b0;
          largest_step_q <= '0;
          largest_dev_q  <= '0;
        end else begin
          prev_q         <= val;
          have_prev_q    <= 1'b1;
          largest_step_q <= new_step;
          largest_dev_q  <= new_dev;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_root_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_ROOT) |-> (!v1_q && !v2_q))
    else $error("root started with products still in flight");

  a_stats_only_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_frame_o) |-> (step_max_o == '0 && deviation_max_o == '0))
    else $error("frame statistics on a beat that is not last");

  a_frame_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_j) |=> (!have_prev_q && largest_step_q == '0 && largest_dev_q == '0))
    else $error("frame tracking not cleared after last output");

endmodule

// ===== sv/weighted_rms_window_filter.sv =====
// weighted_rms_window_filter: top level; config registers, front, job queue, back
// back end: one job at a time, a serial tap multiply-accumulate (2*h+1 taps
//   plus drain) and then a 17-step bit-serial root (h = half width)
// reset: config registers take their defaults, window and frame tracking clear at
//   once; no clearing pass. uses wrms_pkg, wrms_front, wrms_fifo, wrms_back
module weighted_rms_window_filter #(
  parameter int unsigned MaxHalf    = wrms_pkg::MAX_HALF,
  parameter int unsigned QueueDepth = wrms_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [wrms_pkg::WEIGHT_W-1:0]       cfg_data_i,
  // sample beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wrms_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                frame_end_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wrms_pkg::VALUE_W-1:0]        filtered_value_o,
  output logic                                last_of_frame_o,
  output logic [wrms_pkg::VALUE_W-1:0]        step_max_o,
  output logic [wrms_pkg::DEV_W-1:0]          deviation_max_o
);
  import wrms_pkg::*;

  localparam int unsigned JobW = job_w(MaxHalf);

  cfg_t cfg_q;

  logic            push, full, pop, empty;
  logic [JobW-1:0] job_in, job_out;

  // register file; each index maps to one field of the config struct
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_width    <= HALF_WIDTH_RST;
      cfg_q.weight_center <= WEIGHT_CENTER_RST;
      cfg_q.weight_near   <= WEIGHT_NEAR_RST;
      cfg_q.weight_far    <= WEIGHT_FAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HALF_WIDTH:    cfg_q.half_width    <= cfg_data_i[HALF_W-1:0];
        REG_WEIGHT_CENTER: cfg_q.weight_center <= cfg_data_i;
        REG_WEIGHT_NEAR:   cfg_q.weight_near   <= cfg_data_i;
        REG_WEIGHT_FAR:    cfg_q.weight_far    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front: window shift, frame count, job generation (up to MaxHalf+1 jobs on frame end)
  wrms_front #(
    .MaxHalf (MaxHalf)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_width_i (cfg_q.half_width),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .frame_end_i  (frame_end_i),
    .push_o       (push),
    .full_i       (full),
    .job_o        (job_in)
  );

  // job queue lets the front keep taking samples while the back is busy
  wrms_fifo #(
    .Width (JobW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_out)
  );

  // back: weighted sum of squares, root, frame statistics, output register
  wrms_back #(
    .MaxHalf (MaxHalf)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .job_valid_i      (!empty),
    .job_i            (job_out),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_value_o (filtered_value_o),
    .last_of_frame_o  (last_of_frame_o),
    .step_max_o       (step_max_o),
    .deviation_max_o  (deviation_max_o)
  );

endmodule

// ===== dv/testbench.sv =====
// testbench for weighted_rms_window_filter: drives sample frames and register settings,
// predicts every result beat in place and checks each one as it leaves the block
// depends on wrms_pkg and weighted_rms_window_filter
module testbench;
  import wrms_pkg::*;

  // window of samples kept by the predictor, newest at index 0
  localparam int WIN = 2 * MAX_HALF + 1;
  // quiet cycles after the last result before a register write or the end
  localparam int HOLD = 2 * MAX_HALF + 24 + 16;
  // slowest correct run is well below this
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               ends_frame;
    logic [VALUE_W-1:0] step;
    logic [DEV_W-1:0]   dev;
  } rms_beat_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [1:0]                 cfg_index_i = '0;
  logic [WEIGHT_W-1:0]        cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       frame_end_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [VALUE_W-1:0]         filtered_value_o;
  logic                       last_of_frame_o;
  logic [VALUE_W-1:0]         step_max_o;
  logic [DEV_W-1:0]           deviation_max_o;

  weighted_rms_window_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_value_o(filtered_value_o),
    .last_of_frame_o (last_of_frame_o),
    .step_max_o      (step_max_o),
    .deviation_max_o (deviation_max_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers, at their reset values
  logic [HALF_W-1:0]   cfg_half = HALF_WIDTH_RST;
  logic [WEIGHT_W-1:0] w_center = WEIGHT_CENTER_RST;
  logic [WEIGHT_W-1:0] w_near   = WEIGHT_NEAR_RST;
  logic [WEIGHT_W-1:0] w_far    = WEIGHT_FAR_RST;

  // predictor copy of the frame state
  int win [WIN] = '{default: 0};
  int frame_fill = 0;
  int last_out = 0;
  bit have_last = 1'b0;
  int peak_step = 0;
  int peak_dev = 0;

  // result beats owed by the block, oldest first
  rms_beat_t owed_beats[$];

  int  error_count = 0;
  int  beats_sent = 0;
  int  results_seen = 0;
  int  settings_used = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;
  int  quiet_left = 0;

  // floor of the square root, bit by bit from the top
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // one output centred on the sample of the given age; updates frame peaks
  task automatic produce_output(input int age, input int h, input bit ends_frame);
    longint unsigned acc, wt;
    int a, s, val, d;
    rms_beat_t r;
    acc = 0;
    for (int t = -h; t <= h; t++) begin
      a = age + t;
      if (a >= 0 && a < WIN) begin
        s = win[a];
        if (t == 0) wt = w_center;
        else if (t == 1 || t == -1) wt = w_near;
        else if (t == 2 || t == -2) wt = w_far;
        else wt = 0;
        acc += longint'(s * s) * wt;
      end
    end
    val = int'(floor_root(acc >> ACC_SHIFT));
    if (val > 32767) val = 32767;
    if (have_last) begin
      d = val - last_out;
      if (d < 0) d = -d;
      if (d > peak_step) peak_step = d;
    end
    d = val - win[age];
    if (d < 0) d = -d;
    if (d > peak_dev) peak_dev = d;
    last_out = val;
    have_last = 1'b1;
    r.value = val[VALUE_W-1:0];
    r.ends_frame = ends_frame;
    r.step = ends_frame ? peak_step[VALUE_W-1:0] : '0;
    r.dev = ends_frame ? peak_dev[DEV_W-1:0] : '0;
    owed_beats.insert(owed_beats.size(), r);
  endtask

  // predictor: one accepted sample beat
  task automatic filter_sample(input logic signed [SAMPLE_W-1:0] s, input bit ends_frame);
    int h, cnt;
    // half width 0 acts as 1, above the maximum acts as the maximum
    if (cfg_half == 0) h = 1;
    else if (cfg_half > MAX_HALF) h = MAX_HALF;
    else h = int'(cfg_half);
    for (int k = WIN - 1; k > 0; k--) win[k] = win[k - 1];
    win[0] = int'(s);
    if (frame_fill < 7) frame_fill++;
    if (!ends_frame) begin
      if (frame_fill > h) produce_output(h, h, 1'b0);
    end else begin
      // flush every output still owed, then forget the frame
      cnt = (frame_fill > h + 1) ? h + 1 : frame_fill;
      for (int age = cnt - 1; age >= 0; age--) produce_output(age, h, age == 0);
      win = '{default: 0};
      frame_fill = 0;
      last_out = 0;
      have_last = 1'b0;
      peak_step = 0;
      peak_dev = 0;
    end
  endtask

  // one register write; leaves the write enable up for a following write
  task automatic write_reg(input cfg_reg_e idx, input logic [WEIGHT_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_HALF_WIDTH:    cfg_half = data[HALF_W-1:0];
      REG_WEIGHT_CENTER: w_center = data;
      REG_WEIGHT_NEAR:   w_near = data;
      REG_WEIGHT_FAR:    w_far = data;
      default: begin
      end
    endcase
  endtask

  // all four registers; junk in the unused upper bits of the half width
  task automatic load_settings(input logic [HALF_W-1:0] h, input logic [WEIGHT_W-1:0] wc,
                               input logic [WEIGHT_W-1:0] wn, input logic [WEIGHT_W-1:0] wf);
    logic [WEIGHT_W-HALF_W-1:0] junk;
    junk = (WEIGHT_W-HALF_W)'($urandom);
    write_reg(REG_HALF_WIDTH, {junk, h});
    write_reg(REG_WEIGHT_CENTER, wc);
    write_reg(REG_WEIGHT_NEAR, wn);
    write_reg(REG_WEIGHT_FAR, wf);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // send one sample beat, optionally after a random idle burst
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit ends_frame);
    int gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    frame_end_i <= ends_frame;
    // inputs are settled at the falling edge, so the next rising edge takes the beat
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    filter_sample(s, ends_frame);
    beats_sent++;
  endtask

  // hold the sender until every owed result is out, then let the pipe empty
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (HOLD) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $signed(16'($urandom_range(0, 511)) - 16'd256);
      default: return $signed(SAMPLE_W'($urandom));
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // a frame of random length and content
  task automatic send_rand_frame(output int len);
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  // reset settings, sample extremes, then a frame of a single sample
  task automatic test_default_setting();
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    settle_block();
  endtask

  // all weights full scale saturates the root, all weights zero gives zero
  task automatic test_weight_extremes();
    load_settings(2'd2, 16'hffff, 16'hffff, 16'hffff);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    settle_block();
    load_settings(2'd1, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'sd12345, 1'b0);
    send_sample(-16'sd1, 1'b1);
    settle_block();
  endtask

  // half width codes outside the meaningful range clamp
  task automatic test_half_width_codes();
    load_settings(2'd0, 16'd40000, 16'd12000, 16'd50000);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd20000, 1'b0);
    send_sample(16'sd7, 1'b1);
    settle_block();
    load_settings(2'd3, 16'd10000, 16'd20000, 16'hffff);
    send_sample(16'sd30000, 1'b0);
    send_sample(-16'sd4096, 1'b0);
    send_sample(16'sd4096, 1'b1);
    settle_block();
  endtask

  // half width narrowed and widened in the middle of a frame
  task automatic test_mid_frame_change();
    load_settings(2'd2, 16'd30000, 16'd20000, 16'd10000);
    send_sample(16'sd8000, 1'b0);
    send_sample(-16'sd16000, 1'b0);
    send_sample(16'sd24000, 1'b0);
    send_sample(-16'sd32000, 1'b0);
    settle_block();
    load_settings(2'd1, 16'd30000, 16'd20000, 16'd10000);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd200, 1'b1);
    send_sample(16'sd5000, 1'b0);
    send_sample(16'sd6000, 1'b0);
    settle_block();
    load_settings(2'd2, 16'd30000, 16'd20000, 16'd10000);
    send_sample(-16'sd7000, 1'b1);
    settle_block();
  endtask

  // random settings per phase, random frames with idling on both sides
  task automatic test_random_frames();
    int phase_items, len;
    for (int p = 0; p < 6; p++) begin
      load_settings(2'($urandom_range(0, 3)), rand_weight(), rand_weight(), rand_weight());
      phase_items = 0;
      while (phase_items < 18) begin
        send_rand_frame(len);
        phase_items += len;
      end
      settle_block();
    end
  endtask

  // last stretch with no idling on either side
  task automatic test_steady_stream();
    int total, len;
    calm = 1'b1;
    load_settings(2'($urandom_range(1, 2)), rand_weight(), rand_weight(), rand_weight());
    total = 0;
    while (total < 30) begin
      send_rand_frame(len);
      total += len;
    end
  endtask

  // receiver: random stall bursts between quiet stretches
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0 && quiet_left == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          quiet_left = $urandom_range(20, 80);
        end else begin
          stall_left = $urandom_range(1, 6);
          quiet_left = $urandom_range(0, 8);
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (quiet_left > 0) quiet_left--;
      end
    end
  end

  // result check at the falling edge; the beat is taken at the next rising edge
  always @(negedge clk_i) begin : check_results
    rms_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (owed_beats.size() == 0) begin
        $display("%0t unexpected result beat: value %0d last %0b step %0d dev %0d", $time,
                 filtered_value_o, last_of_frame_o, step_max_o, deviation_max_o);
        error_count++;
      end else begin
        want = owed_beats.pop_front();
        if (filtered_value_o !== want.value || last_of_frame_o !== want.ends_frame ||
            step_max_o !== want.step || deviation_max_o !== want.dev) begin
          $display("%0t mismatch: expected value %0d last %0b step %0d dev %0d, got %0d %0b %0d %0d",
                   $time, want.value, want.ends_frame, want.step, want.dev,
                   filtered_value_o, last_of_frame_o, step_max_o, deviation_max_o);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_setting();
    test_weight_extremes();
    test_half_width_codes();
    test_mid_frame_change();
    test_random_frames();
    test_steady_stream();
    settle_block();
    $display("covered %0d sample beats and %0d result beats over %0d register settings",
             beats_sent, results_seen, settings_used);
    $display("incl. clamped half width codes, zero and full scale weights, mid-frame changes");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wrms_pkg.sv
sv/wrms_fifo.sv
sv/wrms_front.sv
sv/wrms_back.sv
sv/weighted_rms_window_filter.sv
dv/testbench.sv
